>>> rtl/csode_pkg.sv
package csode_pkg;

    // Stream payloads
    typedef struct packed {
        logic              action;
        logic signed [31:0] excitation_in;
        logic signed [31:0] recovery_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] excitation_out;
        logic signed [31:0] recovery_out;
        logic               last_cell;
        logic               divide_saturated;
    } out_item_t;

    // Configuration map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int ROW_W      = 13;
    localparam int COLCFG_W   = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS,
        CFG_GRID_COLS,
        CFG_DIFFUSION_GAIN,
        CFG_TIME_STEP,
        CFG_REACTION_GAIN,
        CFG_EXC_THRESHOLD,
        CFG_RECOVERY_OFFSET,
        CFG_RECOVERY_RATE
    } cfg_index_t;

    localparam logic [ROW_W-1:0]      RST_GRID_ROWS  = 13'd400;
    localparam logic [COLCFG_W-1:0]   RST_GRID_COLS  = 10'd400;
    localparam logic [CFG_DATA_W-1:0] RST_DIFFUSION  = 31'd3003122;
    localparam logic [CFG_DATA_W-1:0] RST_TIME_STEP  = 31'd375809;
    localparam logic [CFG_DATA_W-1:0] RST_REACTION   = 31'd134217728;
    localparam logic [CFG_DATA_W-1:0] RST_THRESHOLD  = 31'd1677722;
    localparam logic [CFG_DATA_W-1:0] RST_REC_OFFSET = 31'd1677722;
    localparam logic [CFG_DATA_W-1:0] RST_REC_RATE   = 31'd167772;

    // Coefficients as signed Q8.24 operands
    typedef struct packed {
        logic signed [31:0] alpha;
        logic signed [31:0] dt;
        logic signed [31:0] kk;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] eps;
    } coef_t;

    // Q8.24 constants
    localparam logic signed [31:0] Q_ONE   = 32'sd16777216;
    localparam logic signed [31:0] Q_M1    = 32'sd1174405;
    localparam logic signed [31:0] Q_M2    = 32'sd5033165;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Divider: 32-bit magnitude shifted up by 24 fraction bits
    localparam int DIV_N_W   = 56;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_WR, ST_LAP,
        ST_M_ALPHA, ST_P_E1, ST_M_KE1, ST_P_T1, ST_M_T1, ST_P_T2,
        ST_M_T2, ST_P_T3, ST_M_E1R, ST_P_F, ST_M_DTF, ST_P_E2,
        ST_M_M1R, ST_P_NUM, ST_M_KE2, ST_P_K1, ST_M_K1, ST_P_H,
        ST_WAIT, ST_G, ST_M_GH, ST_P_GH, ST_M_DT, ST_P_R2, ST_OUT
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_RD_A, OP_RD_B, OP_GATHER, OP_LAP,
        OP_M_ALPHA, OP_P_E1, OP_M_KE1, OP_P_T1, OP_M_T1, OP_P_T2,
        OP_M_T2, OP_P_T3, OP_M_E1R, OP_P_F, OP_M_DTF, OP_P_E2,
        OP_M_M1R, OP_P_NUM, OP_M_KE2, OP_P_K1, OP_M_K1, OP_P_H,
        OP_G, OP_M_GH, OP_P_GH, OP_M_DT, OP_P_R2, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   wr_en;
        logic   drain;
        logic   up_from_in;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return S32_MAX;
        end else if (x < -64'sd2147483648) begin
            return S32_MIN;
        end
        return x[31:0];
    endfunction

    // Round half up, floor by 24, saturate
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd8388608) >>> 24;
        return sat32(r);
    endfunction

endpackage

>>> rtl/csode_div.sv
module csode_div
    import csode_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic [DIV_N_W-1:0]   dq_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    // restoring, one quotient bit per cycle
    assign rem_sh  = {rem_reg, dq_reg[DIV_N_W-1]};
    assign ge      = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_N_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            dq_reg  <= {dq_reg[DIV_N_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

>>> rtl/csode_dp.sv
module csode_dp
    import csode_pkg::*;
#(
    parameter int MAX_COLS = 512,
    localparam int EA_W = $clog2(2 * MAX_COLS),
    localparam int CA_W = $clog2(MAX_COLS)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  dp_cmd_t         cmd,
    input  coef_t           coef,
    input  in_item_t        s_item,
    input  logic [EA_W-1:0] rd_addr0,
    input  logic [EA_W-1:0] rd_addr1,
    input  logic [EA_W-1:0] wr_addr,
    input  logic [CA_W-1:0] rec_addr,
    output dp_status_t      status,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data
);

    // line buffers: two excitation rows, one recovery row
    logic signed [31:0] exc_mem [2*MAX_COLS];
    logic signed [31:0] rec_mem [MAX_COLS];

    logic signed [31:0] rd0_reg, rd1_reg, rec_rd_reg;
    logic signed [31:0] ein_reg, rin_reg;
    logic signed [31:0] ec_reg, el_reg, er_reg, eu_reg, ed_reg, rv_reg;
    logic signed [31:0] lap_reg, e1_reg, t_reg, d1_reg, d2_reg, e2_reg;
    logic signed [31:0] d3_reg, nrv_reg, den_reg, h_reg, g_reg, r2_reg;
    logic signed [63:0] prod_reg;
    logic               num_neg_reg, quo_neg_reg, den_zero_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [31:0] qr;
    logic signed [31:0] q_sel;
    logic [31:0]        qr_u, den_u, num_mag, den_mag;
    logic [DIV_N_W-1:0] quo;
    logic               div_done;

    assign qr      = qround(prod_reg);
    assign qr_u    = qr;
    assign den_u   = den_reg;
    assign num_mag = qr_u[31] ? (~qr_u + 32'd1) : qr_u;
    assign den_mag = den_u[31] ? (~den_u + 32'd1) : den_u;

    csode_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == OP_P_NUM),
        .dividend ({num_mag, 24'd0}),
        .divisor  (den_mag),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb begin
        if (den_zero_reg) begin
            q_sel = num_neg_reg ? S32_MIN : S32_MAX;
        end else if (quo_neg_reg) begin
            q_sel = (quo > 56'd2147483648) ? S32_MIN : $signed(~quo[31:0] + 32'd1);
        end else begin
            q_sel = (quo > 56'd2147483647) ? S32_MAX : $signed(quo[31:0]);
        end
    end

    always_comb begin
        unique case (cmd.op)
            OP_M_ALPHA: begin mul_a = coef.alpha; mul_b = lap_reg; end
            OP_M_KE1:   begin mul_a = coef.kk;    mul_b = e1_reg;  end
            OP_M_T1:    begin mul_a = t_reg;      mul_b = d1_reg;  end
            OP_M_T2:    begin mul_a = t_reg;      mul_b = d2_reg;  end
            OP_M_E1R:   begin mul_a = e1_reg;     mul_b = rv_reg;  end
            OP_M_DTF:   begin mul_a = coef.dt;    mul_b = t_reg;   end
            OP_M_M1R:   begin mul_a = Q_M1;       mul_b = rv_reg;  end
            OP_M_KE2:   begin mul_a = coef.kk;    mul_b = e2_reg;  end
            OP_M_K1:    begin mul_a = t_reg;      mul_b = d3_reg;  end
            OP_M_GH:    begin mul_a = g_reg;      mul_b = h_reg;   end
            OP_M_DT:    begin mul_a = coef.dt;    mul_b = t_reg;   end
            default:    begin mul_a = '0;         mul_b = '0;      end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.op)
            OP_LOAD: begin
                ein_reg <= s_item.excitation_in;
                rin_reg <= s_item.recovery_in;
            end
            OP_RD_B: begin
                ec_reg <= rd0_reg;
                el_reg <= rd1_reg;
                rv_reg <= rec_rd_reg;
            end
            OP_GATHER: begin
                er_reg <= rd0_reg;
                eu_reg <= cmd.up_from_in ? ein_reg : rd1_reg;
                ed_reg <= cmd.drain ? rd1_reg : ein_reg;
            end
            OP_LAP: begin
                lap_reg <= sat32(64'(el_reg) + 64'(er_reg) + 64'(eu_reg) + 64'(ed_reg)
                                 - (64'(ec_reg) <<< 2));
            end
            OP_P_E1: e1_reg <= sat32(64'(ec_reg) + 64'(qr));
            OP_P_T1: begin
                t_reg  <= qr;
                d1_reg <= sat32(64'(e1_reg) - 64'(coef.a));
                d2_reg <= sat32(64'(e1_reg) - 64'(Q_ONE));
            end
            OP_P_T2, OP_P_T3, OP_P_K1, OP_P_GH: t_reg <= qr;
            OP_P_F:  t_reg  <= sat32(64'(t_reg) + 64'(qr));
            OP_P_E2: e2_reg <= sat32(64'(e1_reg) - 64'(qr));
            OP_M_M1R: begin
                den_reg <= sat32(64'(e2_reg) + 64'(Q_M2));
                d3_reg  <= sat32(64'(e2_reg) - 64'(coef.b) - 64'(Q_ONE));
                nrv_reg <= sat32(-64'(rv_reg));
            end
            OP_P_NUM: begin
                num_neg_reg  <= qr[31];
                quo_neg_reg  <= qr[31] ^ den_reg[31];
                den_zero_reg <= (den_reg == 32'sd0);
            end
            OP_P_H:  h_reg  <= sat32(64'(nrv_reg) - 64'(qr));
            OP_G:    g_reg  <= sat32(64'(coef.eps) + 64'(q_sel));
            OP_P_R2: r2_reg <= sat32(64'(rv_reg) + 64'(qr));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_RD_A || cmd.op == OP_RD_B) begin
            rd0_reg <= exc_mem[rd_addr0];
            rd1_reg <= exc_mem[rd_addr1];
        end
        if (cmd.op == OP_RD_A) begin
            rec_rd_reg <= rec_mem[rec_addr];
        end
        if (cmd.wr_en) begin
            exc_mem[wr_addr]  <= ein_reg;
            rec_mem[rec_addr] <= rin_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT) begin
            m_data_reg.excitation_out   <= e2_reg;
            m_data_reg.recovery_out     <= r2_reg;
            m_data_reg.last_cell        <= cmd.last;
            m_data_reg.divide_saturated <= den_zero_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

>>> rtl/csode_ctrl.sv
module csode_ctrl
    import csode_pkg::*;
#(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 4096,
    localparam int EA_W = $clog2(2 * MAX_COLS),
    localparam int CA_W = $clog2(MAX_COLS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_action,
    output logic                s_ready,
    input  logic [ROW_W-1:0]    grid_rows,
    input  logic [COLCFG_W-1:0] grid_cols,
    input  dp_status_t          status,
    output dp_cmd_t             cmd,
    output logic [EA_W-1:0]     rd_addr0,
    output logic [EA_W-1:0]     rd_addr1,
    output logic [EA_W-1:0]     wr_addr,
    output logic [CA_W-1:0]     rec_addr
);

    ctrl_state_t state_reg, state_next;

    logic [ROW_W-1:0] row_count_reg;
    logic [CA_W-1:0]  col_count_reg;
    logic             draining_reg;

    // per-request context
    logic [CA_W-1:0] c_reg, cl_reg, cr_reg;
    logic            slot_reg, drain_reg, up_in_reg, last_reg, wr_reg;

    logic [ROW_W-1:0]    rows_eff;
    logic [COLCFG_W-1:0] cols_eff;
    logic [ROW_W-1:0]    row_inc;
    logic [CA_W-1:0]     col_l, col_r;
    logic                accept, ignore, col_wrap;

    function automatic logic [EA_W-1:0] eaddr(input logic row_bit, input logic [CA_W-1:0] col);
        return row_bit ? EA_W'(MAX_COLS) + EA_W'(col) : EA_W'(col);
    endfunction

    assign rows_eff = (grid_rows < 13'd3) ? 13'd3 :
                      ((32'(grid_rows) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : grid_rows);
    assign cols_eff = (grid_cols < 10'd3) ? 10'd3 :
                      ((32'(grid_cols) > MAX_COLS) ? COLCFG_W'(MAX_COLS) : grid_cols);

    assign accept   = s_valid && s_ready;
    assign ignore   = s_action ? !draining_reg : draining_reg;
    assign col_wrap = (32'(col_count_reg) + 32'd1) >= 32'(cols_eff);
    assign row_inc  = row_count_reg + 1'b1;
    // mirror at left and right edges
    assign col_l    = (col_count_reg == '0) ? CA_W'(1) : col_count_reg - 1'b1;
    assign col_r    = ((32'(col_count_reg) + 32'd1) < 32'(cols_eff)) ?
                      col_count_reg + 1'b1 : col_count_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            col_count_reg <= '0;
            draining_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && !ignore) begin
                if (s_action) begin
                    if (col_wrap) begin
                        col_count_reg <= '0;
                        row_count_reg <= '0;
                        draining_reg  <= 1'b0;
                    end else begin
                        col_count_reg <= col_count_reg + 1'b1;
                    end
                end else begin
                    if (col_wrap) begin
                        col_count_reg <= '0;
                        row_count_reg <= row_inc;
                        if (row_inc >= rows_eff) begin
                            draining_reg <= 1'b1;
                        end
                    end else begin
                        col_count_reg <= col_count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            c_reg     <= col_count_reg;
            cl_reg    <= col_l;
            cr_reg    <= col_r;
            slot_reg  <= row_count_reg[0];
            drain_reg <= s_action;
            up_in_reg <= (row_count_reg == 13'd1);
            last_reg  <= s_action && col_wrap;
            wr_reg    <= !s_action;
        end
    end

    // next state
    always_comb begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !ignore) begin
                    state_next = (!s_action && row_count_reg == '0) ? ST_WR : ST_RD0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR:      state_next = ST_IDLE;
            ST_RD0:     state_next = ST_RD1;
            ST_RD1:     state_next = ST_RD2;
            ST_RD2:     state_next = ST_LAP;
            ST_LAP:     state_next = ST_M_ALPHA;
            ST_M_ALPHA: state_next = ST_P_E1;
            ST_P_E1:    state_next = ST_M_KE1;
            ST_M_KE1:   state_next = ST_P_T1;
            ST_P_T1:    state_next = ST_M_T1;
            ST_M_T1:    state_next = ST_P_T2;
            ST_P_T2:    state_next = ST_M_T2;
            ST_M_T2:    state_next = ST_P_T3;
            ST_P_T3:    state_next = ST_M_E1R;
            ST_M_E1R:   state_next = ST_P_F;
            ST_P_F:     state_next = ST_M_DTF;
            ST_M_DTF:   state_next = ST_P_E2;
            ST_P_E2:    state_next = ST_M_M1R;
            ST_M_M1R:   state_next = ST_P_NUM;
            ST_P_NUM:   state_next = ST_M_KE2;
            ST_M_KE2:   state_next = ST_P_K1;
            ST_P_K1:    state_next = ST_M_K1;
            ST_M_K1:    state_next = ST_P_H;
            ST_P_H:     state_next = ST_WAIT;
            ST_WAIT:    state_next = status.div_done ? ST_G : ST_WAIT;
            ST_G:       state_next = ST_M_GH;
            ST_M_GH:    state_next = ST_P_GH;
            ST_P_GH:    state_next = ST_M_DT;
            ST_M_DT:    state_next = ST_P_R2;
            ST_P_R2:    state_next = ST_OUT;
            ST_OUT:     state_next = status.out_free ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd.wr_en      = (state_reg == ST_WR) || (state_reg == ST_RD2 && wr_reg);
        cmd.drain      = drain_reg;
        cmd.up_from_in = up_in_reg;
        cmd.last       = last_reg;
        unique case (state_reg)
            ST_IDLE:    cmd.op = accept ? OP_LOAD : OP_NONE;
            ST_RD0:     cmd.op = OP_RD_A;
            ST_RD1:     cmd.op = OP_RD_B;
            ST_RD2:     cmd.op = OP_GATHER;
            ST_LAP:     cmd.op = OP_LAP;
            ST_M_ALPHA: cmd.op = OP_M_ALPHA;
            ST_P_E1:    cmd.op = OP_P_E1;
            ST_M_KE1:   cmd.op = OP_M_KE1;
            ST_P_T1:    cmd.op = OP_P_T1;
            ST_M_T1:    cmd.op = OP_M_T1;
            ST_P_T2:    cmd.op = OP_P_T2;
            ST_M_T2:    cmd.op = OP_M_T2;
            ST_P_T3:    cmd.op = OP_P_T3;
            ST_M_E1R:   cmd.op = OP_M_E1R;
            ST_P_F:     cmd.op = OP_P_F;
            ST_M_DTF:   cmd.op = OP_M_DTF;
            ST_P_E2:    cmd.op = OP_P_E2;
            ST_M_M1R:   cmd.op = OP_M_M1R;
            ST_P_NUM:   cmd.op = OP_P_NUM;
            ST_M_KE2:   cmd.op = OP_M_KE2;
            ST_P_K1:    cmd.op = OP_P_K1;
            ST_M_K1:    cmd.op = OP_M_K1;
            ST_P_H:     cmd.op = OP_P_H;
            ST_G:       cmd.op = OP_G;
            ST_M_GH:    cmd.op = OP_M_GH;
            ST_P_GH:    cmd.op = OP_P_GH;
            ST_M_DT:    cmd.op = OP_M_DT;
            ST_P_R2:    cmd.op = OP_P_R2;
            ST_OUT:     cmd.op = status.out_free ? OP_OUT : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    // center row sits in the slot opposite the incoming row
    assign rd_addr0 = (state_reg == ST_RD1) ? eaddr(!slot_reg, cr_reg) : eaddr(!slot_reg, c_reg);
    assign rd_addr1 = (state_reg == ST_RD1) ? eaddr(slot_reg, c_reg) : eaddr(!slot_reg, cl_reg);
    assign wr_addr  = eaddr(slot_reg, c_reg);
    assign rec_addr = c_reg;

endmodule

>>> rtl/cardiac_stencil_ode_step.sv
// One explicit time step of the Aliev-Panfilov cardiac model over a grid that
// arrives in raster order, one cell per request on the s_ channel. Two
// excitation rows and one recovery row are held in on-chip line buffers, so
// results on the m_ channel lag the input by one row; after the last grid row,
// send one drain request (action = 1) per column to flush the final row, whose
// last result carries last_cell. Cells of the first row only fill the buffers.
// A cell sent while draining, or a drain request sent while not draining, is
// consumed without a result. Each cell gets a mirrored five-point Laplacian,
// the cubic reaction term and the recovery update, all in saturating signed
// Q8.24. A zero divisor in the recovery quotient saturates it and raises
// divide_saturated. A cell that yields a result goes through the bit-serial
// divider and a chain of dependent multiplies on one shared 32x32
// multiplier, while a first-row cell is only written to the buffers and an
// ignored request is dropped. One request is in flight at a time, but the next
// one is taken while a finished result still waits in the output register.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) must be made while
// the block is idle. Grid sizes are clamped to 3..MAX_ROWS and 3..MAX_COLS.
module cardiac_stencil_ode_step
    import csode_pkg::*;
#(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int EA_W = $clog2(2 * MAX_COLS);
    localparam int CA_W = $clog2(MAX_COLS);

    // configuration registers
    logic [ROW_W-1:0]      grid_rows_reg;
    logic [COLCFG_W-1:0]   grid_cols_reg;
    logic [CFG_DATA_W-1:0] alpha_reg, dt_reg, kk_reg, thr_reg, boff_reg, eps_reg;

    coef_t      coef;
    dp_cmd_t    cmd;
    dp_status_t status;

    logic [EA_W-1:0] rd_addr0, rd_addr1, wr_addr;
    logic [CA_W-1:0] rec_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= RST_GRID_ROWS;
            grid_cols_reg <= RST_GRID_COLS;
            alpha_reg     <= RST_DIFFUSION;
            dt_reg        <= RST_TIME_STEP;
            kk_reg        <= RST_REACTION;
            thr_reg       <= RST_THRESHOLD;
            boff_reg      <= RST_REC_OFFSET;
            eps_reg       <= RST_REC_RATE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GRID_ROWS:       grid_rows_reg <= cfg_wdata[ROW_W-1:0];
                CFG_GRID_COLS:       grid_cols_reg <= cfg_wdata[COLCFG_W-1:0];
                CFG_DIFFUSION_GAIN:  alpha_reg     <= cfg_wdata;
                CFG_TIME_STEP:       dt_reg        <= cfg_wdata;
                CFG_REACTION_GAIN:   kk_reg        <= cfg_wdata;
                CFG_EXC_THRESHOLD:   thr_reg       <= cfg_wdata;
                CFG_RECOVERY_OFFSET: boff_reg      <= cfg_wdata;
                CFG_RECOVERY_RATE:   eps_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // coefficients are non-negative, zero-extend into signed operands
    assign coef.alpha = $signed({1'b0, alpha_reg});
    assign coef.dt    = $signed({1'b0, dt_reg});
    assign coef.kk    = $signed({1'b0, kk_reg});
    assign coef.a     = $signed({1'b0, thr_reg});
    assign coef.b     = $signed({1'b0, boff_reg});
    assign coef.eps   = $signed({1'b0, eps_reg});

    csode_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_action  (s_data.action),
        .s_ready   (s_ready),
        .grid_rows (grid_rows_reg),
        .grid_cols (grid_cols_reg),
        .status    (status),
        .cmd       (cmd),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .wr_addr   (wr_addr),
        .rec_addr  (rec_addr)
    );

    csode_dp #(
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .coef     (coef),
        .s_item   (s_data),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .wr_addr  (wr_addr),
        .rec_addr (rec_addr),
        .status   (status),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
